// ===== hdl/uartrb_pkg.sv =====
`default_nettype none

package uartrb_pkg;

    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 32;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int BYTE_W   = 8;

    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    typedef enum logic [1:0] {
        OP_LINE_RX = 2'd0,
        OP_HOST_RD = 2'd1,
        OP_HOST_WR = 2'd2,
        OP_TX_RDY  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_FRAME   = 3'd1,
        ERR_OVERRUN = 3'd2,
        ERR_PARITY  = 3'd3,
        ERR_FULL    = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    // Command from the sequencer to the pointer logic.
    typedef struct packed {
        logic go;
        t_op  op;
        logic fe;
        logic dor;
        logic pe;
    } t_cmd;

    // Memory controls and step outcome from the pointer logic.
    typedef struct packed {
        logic             rx_wr_en;
        logic [RX_AW-1:0] rx_head;
        logic [RX_AW-1:0] rx_tail;
        logic             rx_deq;
        logic             tx_wr_en;
        logic [TX_AW-1:0] tx_head;
        logic [TX_AW-1:0] tx_tail;
        logic             tx_deq;
        logic             wr_ok;
        t_err             err;
        logic             irq;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/uartrb_ram.sv =====
`default_nettype none

module uartrb_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/uartrb_ptrs.sv =====
`default_nettype none

module uartrb_ptrs (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire uartrb_pkg::t_cmd i_cmd,
    output uartrb_pkg::t_stat     o_stat
);

    logic [uartrb_pkg::RX_AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [uartrb_pkg::TX_AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    uartrb_pkg::t_err             r_err, n_err;
    logic                         r_irq, n_irq;

    logic [uartrb_pkg::RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic [uartrb_pkg::TX_AW-1:0] tx_head_inc, tx_tail_inc;
    logic                         rx_full, rx_empty, tx_full, tx_empty;
    logic                         rx_wr, rx_deq, tx_wr, tx_deq;

    // ring increments, one slot always kept empty
    assign rx_head_inc = (r_rx_head == uartrb_pkg::RX_LAST) ? '0 : r_rx_head + 1'b1;
    assign rx_tail_inc = (r_rx_tail == uartrb_pkg::RX_LAST) ? '0 : r_rx_tail + 1'b1;
    assign tx_head_inc = (r_tx_head == uartrb_pkg::TX_LAST) ? '0 : r_tx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == uartrb_pkg::TX_LAST) ? '0 : r_tx_tail + 1'b1;

    assign rx_full  = (rx_head_inc == r_rx_tail);
    assign rx_empty = (r_rx_head == r_rx_tail);
    assign tx_full  = (tx_head_inc == r_tx_tail);
    assign tx_empty = (r_tx_head == r_tx_tail);

    always_comb begin
        rx_wr  = 1'b0;
        rx_deq = 1'b0;
        tx_wr  = 1'b0;
        tx_deq = 1'b0;
        n_err  = r_err;
        n_irq  = r_irq;
        if (i_cmd.go) begin
            case (i_cmd.op)
                uartrb_pkg::OP_LINE_RX: begin
                    // error priority: frame, overrun, parity, full
                    if (i_cmd.fe) begin
                        n_err = uartrb_pkg::ERR_FRAME;
                    end else if (i_cmd.dor) begin
                        n_err = uartrb_pkg::ERR_OVERRUN;
                    end else if (i_cmd.pe) begin
                        n_err = uartrb_pkg::ERR_PARITY;
                    end else if (rx_full) begin
                        n_err = uartrb_pkg::ERR_FULL;
                    end else begin
                        rx_wr = 1'b1;
                    end
                end
                uartrb_pkg::OP_HOST_RD: begin
                    rx_deq = !rx_empty;
                end
                uartrb_pkg::OP_HOST_WR: begin
                    if (!tx_full) begin
                        tx_wr = 1'b1;
                        n_irq = 1'b1;
                    end
                end
                uartrb_pkg::OP_TX_RDY: begin
                    if (tx_empty) begin
                        n_irq = 1'b0;
                    end else begin
                        tx_deq = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign n_rx_head = rx_wr  ? rx_head_inc : r_rx_head;
    assign n_rx_tail = rx_deq ? rx_tail_inc : r_rx_tail;
    assign n_tx_head = tx_wr  ? tx_head_inc : r_tx_head;
    assign n_tx_tail = tx_deq ? tx_tail_inc : r_tx_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_err     <= uartrb_pkg::ERR_NONE;
            r_irq     <= 1'b0;
        end else begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_err     <= n_err;
            r_irq     <= n_irq;
        end
    end

    always_comb begin
        o_stat.rx_wr_en = rx_wr;
        o_stat.rx_head  = r_rx_head;
        o_stat.rx_tail  = r_rx_tail;
        o_stat.rx_deq   = rx_deq;
        o_stat.tx_wr_en = tx_wr;
        o_stat.tx_head  = r_tx_head;
        o_stat.tx_tail  = r_tx_tail;
        o_stat.tx_deq   = tx_deq;
        o_stat.wr_ok    = tx_wr;
        o_stat.err      = n_err;
        o_stat.irq      = n_irq;
    end

    a_rx_deq_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_deq |-> (r_rx_head != r_rx_tail))
        else $error("rx dequeue from empty ring");

    a_rx_wr_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_wr |=> (r_rx_head != r_rx_tail))
        else $error("rx ring empty after enqueue");

    a_tx_wr_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_wr |=> (r_irq && (r_tx_head != r_tx_tail)))
        else $error("tx enqueue did not set irq enable or fill ring");

endmodule

`default_nettype wire

// ===== hdl/uart_rx_tx_ring_buffers_unit.sv =====
`default_nettype none

// Buffered serial-port FIFO pair: a receive ring and a transmit ring, each
// holding up to DEPTH-1 characters in a one-read, one-write memory.
// Input channel (i_in_valid / o_in_stall): one operation per transfer --
//   line byte received (with frame/overrun/parity status), host read,
//   host write, or transmitter ready.
// Output channel (o_out_valid / i_out_stall): exactly one result per input
//   transfer, in order: read byte and availability, write accepted, dequeued
//   transmit byte, interrupt enable and the sticky last-error code.
// Timing: operations that need no memory read (line byte, host write, host
//   read on empty ring, transmitter ready on empty ring) present their result
//   in the cycle after the input transfer. A dequeue reads the ring memory
//   (registered read); its result goes through the memory read register
//   and then the output register. One operation per cycle while the receiver
//   does not stall; a dequeue holds off input until its result is loaded.
// Reset (synchronous, active low) empties both rings, clears the error code
//   and the interrupt enable; memory contents are not cleared and need not be.
// When the receiver stalls, the result stays in the output register and one
//   more operation is taken only once that register is being emptied.
module uart_rx_tx_ring_buffers_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [uartrb_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                          i_frame_error,
    input  wire logic                          i_data_overrun,
    input  wire logic                          i_parity_error,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [uartrb_pkg::BYTE_W-1:0]      o_read_byte,
    output logic                               o_char_available,
    output logic                               o_write_accepted,
    output logic [uartrb_pkg::BYTE_W-1:0]      o_tx_byte,
    output logic                               o_tx_valid,
    output logic                               o_tx_irq_enable,
    output logic [2:0]                         o_last_error
);

    uartrb_pkg::t_state r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic               r_deq_rx;       // pending dequeue is from receive ring

    uartrb_pkg::t_cmd cmd;
    uartrb_pkg::t_stat stat;

    logic [uartrb_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
    logic                          in_xfer, slot_free, deq, ld_now, ld_read;

    // output register free, or being taken this cycle
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == uartrb_pkg::S_IDLE) && slot_free);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        cmd.go  = in_xfer;
        cmd.op  = uartrb_pkg::t_op'(i_operation);
        cmd.fe  = i_frame_error;
        cmd.dor = i_data_overrun;
        cmd.pe  = i_parity_error;
    end

    uartrb_ptrs u_ptrs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

    // Read address follows the tail pointer: the word at the old tail is
    // captured at the same edge that advances the tail.
    uartrb_ram #(
        .DEPTH (uartrb_pkg::RX_DEPTH),
        .WIDTH (uartrb_pkg::BYTE_W)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stat.rx_wr_en),
        .i_wr_addr (stat.rx_head),
        .i_wr_data (i_data_byte),
        .i_rd_addr (stat.rx_tail),
        .o_rd_data (rx_rdata)
    );

    uartrb_ram #(
        .DEPTH (uartrb_pkg::TX_DEPTH),
        .WIDTH (uartrb_pkg::BYTE_W)
    ) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stat.tx_wr_en),
        .i_wr_addr (stat.tx_head),
        .i_wr_data (i_data_byte),
        .i_rd_addr (stat.tx_tail),
        .o_rd_data (tx_rdata)
    );

    assign deq     = stat.rx_deq || stat.tx_deq;
    assign ld_now  = in_xfer && !deq;
    assign ld_read = (r_state == uartrb_pkg::S_READ);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            uartrb_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (deq) begin
                        n_state = uartrb_pkg::S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            uartrb_pkg::S_READ: begin
                n_state     = uartrb_pkg::S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = uartrb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= uartrb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_deq_rx <= stat.rx_deq;
        end
        if (ld_now) begin
            o_read_byte      <= '0;
            o_char_available <= 1'b0;
            o_write_accepted <= stat.wr_ok;
            o_tx_byte        <= '0;
            o_tx_valid       <= 1'b0;
            o_tx_irq_enable  <= stat.irq;
            o_last_error     <= stat.err;
        end else if (ld_read) begin
            o_read_byte      <= r_deq_rx ? rx_rdata : '0;
            o_char_available <= r_deq_rx;
            o_write_accepted <= 1'b0;
            o_tx_byte        <= r_deq_rx ? '0 : tx_rdata;
            o_tx_valid       <= !r_deq_rx;
            o_tx_irq_enable  <= stat.irq;
            o_last_error     <= stat.err;
        end
    end

    assign o_out_valid = r_out_valid;

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uartrb_pkg::S_READ) |-> !r_out_valid)
        else $error("output register busy during memory read");

    a_deq_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && deq) |=> (r_state == uartrb_pkg::S_READ))
        else $error("dequeue did not enter read state");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uartrb_pkg::S_READ) |=>
            ((r_state == uartrb_pkg::S_IDLE) && r_out_valid))
        else $error("read state did not produce a result");

endmodule

`default_nettype wire
